### hdl/mscc_pkg.sv
package mscc_pkg;

  // field and register widths
  localparam int unsigned RAW_W    = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned NORM_W   = 18;
  localparam int unsigned GAIN_W   = 12;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // shared multiplier operand and product widths
  localparam int unsigned OPA_W  = 18;
  localparam int unsigned OPB_W  = 17;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  localparam int unsigned NORM_SHIFT  = 14;
  localparam int unsigned GAIN_FRAC   = 8;
  localparam int unsigned ALPHA_FRAC  = 15;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 12'd512;
  localparam logic [THR_W-1:0]   GATE_RESET  = 16'd500;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd13107;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 16'd32768;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN  = 2'd0,
    REG_GATE  = 2'd1,
    REG_ALPHA = 2'd2
  } reg_idx_t;

endpackage

### hdl/mic_sample_conditioning_chain.sv
// channel  | direction | tdata fields (low bit up)      | width
// s_axis   | in        | raw_word                       | 32
// m_axis   | out       | filtered_sample                | 16
// cfg      | in        | gain, gate_threshold, alpha    | 16
//
// each item runs through these steps in order: accept (gain product), gate plus alpha
// product, (1-alpha)*previous product, sum and output load; one shared 18x17 multiplier
// makes the steps run one after another, as every step waits for its product register.
// s_tready is high only while the sequencer is idle; the final step waits while
// the output register still holds a result that is not taken.
// rst is synchronous, active high; registers return to their reset values and
// the previous output to zero.
module mic_sample_conditioning_chain (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mscc_pkg::RAW_W-1:0]          s_tdata,   // [31:0] raw_word
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mscc_pkg::SAMPLE_W-1:0]       m_tdata,   // [15:0] filtered_sample
  input  logic                                cfg_we,
  input  logic [mscc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mscc_pkg::CFG_W-1:0]          cfg_data
);
  import mscc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_GATE = 4'b0010,
    ST_PREV = 4'b0100,
    ST_SUM  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [GAIN_W-1:0]          gain;
  logic [THR_W-1:0]           gate_threshold;
  logic [ALPHA_W-1:0]         smoothing_alpha;
  logic signed [SAMPLE_W-1:0] previous_output;

  logic signed [PROD_W-1:0]   prod, prod_next;
  logic signed [PROD_W-1:0]   acc;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;

  logic signed [PROD_W-1:0]   gain_q;
  logic signed [SAMPLE_W-1:0] x_sat;
  logic signed [SAMPLE_W-1:0] x_gated;
  logic [SAMPLE_W:0]          x_mag;
  logic [ALPHA_W-1:0]         alpha_c;
  logic [ALPHA_W-1:0]         alpha_rest;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_rnd;
  logic signed [SAMPLE_W-1:0] y;

  logic out_valid;
  logic signed [SAMPLE_W-1:0] out_data;
  logic load_out;
  logic accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign load_out = (state == ST_SUM) && (!out_valid || m_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= GAIN_RESET;
      gate_threshold  <= GATE_RESET;
      smoothing_alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:  gain            <= cfg_data[GAIN_W-1:0];
        REG_GATE:  gate_threshold  <= cfg_data[THR_W-1:0];
        REG_ALPHA: smoothing_alpha <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // alpha clamp and its complement
  always_comb begin
    alpha_c    = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;
    alpha_rest = ALPHA_ONE - alpha_c;
  end

  // gain product: divide by 256 toward zero, saturate, gate
  always_comb begin
    gain_q = (prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0))) >>> GAIN_FRAC;
    if (gain_q > PROD_W'(32767))
      x_sat = 16'sh7fff;
    else if (gain_q < -PROD_W'(32768))
      x_sat = -16'sh8000;
    else
      x_sat = gain_q[SAMPLE_W-1:0];
    x_mag   = x_sat[SAMPLE_W-1] ? (SAMPLE_W+1)'(-{x_sat[SAMPLE_W-1], x_sat})
                                : {1'b0, x_sat};
    x_gated = (x_mag < {1'b0, gate_threshold}) ? '0 : x_sat;
  end

  // shared multiplier operand selection
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        op_a = $signed(s_tdata[RAW_W-1:NORM_SHIFT]);
        op_b = $signed({{(OPB_W-GAIN_W){1'b0}}, gain});
      end
      ST_GATE: begin
        op_a = OPA_W'(x_gated);
        op_b = $signed({1'b0, alpha_c});
      end
      ST_PREV: begin
        op_a = OPA_W'(previous_output);
        op_b = $signed({1'b0, alpha_rest});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_next = op_a * op_b;
  end

  // filter sum: divide by 32768 toward zero
  always_comb begin
    sum     = SUM_W'(acc) + SUM_W'(prod);
    sum_rnd = sum + (sum[SUM_W-1] ? SUM_W'(32767) : SUM_W'(0));
    y       = sum_rnd[ALPHA_FRAC+SAMPLE_W-1:ALPHA_FRAC];
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_GATE;
      ST_GATE: state_next = ST_PREV;
      ST_PREV: state_next = ST_SUM;
      ST_SUM:  if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // product and accumulator registers
  always_ff @(posedge clk) begin
    if (state != ST_SUM) begin
      prod <= prod_next;
    end
    if (state == ST_PREV) begin
      acc <= prod;
    end
  end

  // output register and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      previous_output <= '0;
    end else begin
      if (load_out) begin
        out_valid       <= 1'b1;
        previous_output <= y;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= y;
    end
  end

  // checks
  a_accept_to_gate: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_GATE)
    else $error("accepted request did not start the gate step");

  a_fixed_steps: assert property (@(posedge clk) disable iff (rst)
    state == ST_GATE |=> state == ST_PREV ##1 state == ST_SUM)
    else $error("sequencer left its fixed multiply steps");

  a_prev_matches_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> previous_output == out_data)
    else $error("filter state differs from the pending result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready)
    else $error("input ready while an item is in work");

endmodule

### bench/tb_mic_sample_conditioning_chain.sv
module tb_mic_sample_conditioning_chain;
  timeunit 1ns;
  timeprecision 1ps;

  import mscc_pkg::*;

  // receiver behaviour
  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_t;

  // index that no register answers to
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint GAIN_SCALE  = longint'(1) << GAIN_FRAC;
  localparam longint ALPHA_UNITY = longint'(1) << ALPHA_FRAC;
  localparam longint SAT_MAX     = 32767;
  localparam longint SAT_MIN     = -32768;
  localparam longint TOP_MAX     = 131071;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [RAW_W-1:0]      s_tdata = '0;     // [31:0] raw_word
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;          // [15:0] filtered_sample
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // predictor state
  logic [GAIN_W-1:0]     model_gain;
  logic [THR_W-1:0]      model_threshold;
  logic [ALPHA_W-1:0]    model_alpha;
  logic [SAMPLE_W-1:0]   model_prev;

  logic [SAMPLE_W-1:0]   pending_samples[$];
  int                    error_count = 0;
  ready_mode_t           ready_mode = READY_ALWAYS;
  bit                    hold_pending = 1'b0;
  int                    hold_cycles = 150;
  int                    hold_left = 0;
  int                    pattern_phase = 0;

  mic_sample_conditioning_chain dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // gain, clip, gate and smooth one raw word, advancing the filter memory
  function automatic logic [SAMPLE_W-1:0] condition_sample(input logic [RAW_W-1:0] raw);
    longint top;
    longint scaled;
    longint mag;
    longint weight;
    longint mix;
    longint y;
    top = longint'($signed(raw[RAW_W-1:NORM_SHIFT]));
    scaled = (top * longint'(model_gain)) / GAIN_SCALE;
    if (scaled > SAT_MAX) scaled = SAT_MAX;
    if (scaled < SAT_MIN) scaled = SAT_MIN;
    mag = (scaled < 0) ? -scaled : scaled;
    if (mag < longint'(model_threshold)) scaled = 0;
    weight = longint'(model_alpha);
    if (weight > ALPHA_UNITY) weight = ALPHA_UNITY;
    mix = weight * scaled + (ALPHA_UNITY - weight) * longint'($signed(model_prev));
    y = mix / ALPHA_UNITY;
    if (y > SAT_MAX) y = SAT_MAX;
    if (y < SAT_MIN) y = SAT_MIN;
    model_prev = y[SAMPLE_W-1:0];
    return y[SAMPLE_W-1:0];
  endfunction

  // raw word whose top 18 bits are the given value
  function automatic logic [RAW_W-1:0] word_of(input longint top);
    return {top[NORM_W-1:0], {NORM_SHIFT{1'b0}}};
  endfunction

  // random word: full range, near the gate edge, small, or close to full scale
  function automatic logic [RAW_W-1:0] pick_word();
    longint top;
    logic [NORM_SHIFT-1:0] low;
    low = NORM_SHIFT'($urandom);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        if (model_gain == 0) return $urandom;
        top = (longint'(model_threshold) * GAIN_SCALE) / longint'(model_gain)
              + longint'($urandom_range(0, 4)) - 2;
        if (top > TOP_MAX) top = TOP_MAX;
        if (top < 0) top = 0;
        if ($urandom_range(0, 1)) top = -top;
      end
      2: top = longint'($urandom_range(0, 4095)) - 2048;
      default: begin
        top = TOP_MAX - longint'($urandom_range(0, 64));
        if ($urandom_range(0, 1)) top = -top - 1;
      end
    endcase
    return {top[NORM_W-1:0], low};
  endfunction

  // register write once the block is empty, mirrored into the predictor
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN:  model_gain = value[GAIN_W-1:0];
      REG_GATE:  model_threshold = value[THR_W-1:0];
      REG_ALPHA: model_alpha = value[ALPHA_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] thr,
                         input logic [CFG_W-1:0] alpha);
    set_register(REG_GAIN, gain);
    set_register(REG_GATE, thr);
    set_register(REG_ALPHA, alpha);
  endtask

  // offer one word and hold it until the block takes the request
  task automatic send_word(input logic [RAW_W-1:0] raw);
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_samples.push_back(condition_sample(raw));
  endtask

  // random words in bursts, optionally with gaps between bursts
  task automatic send_stream(input int count, input bit with_gaps);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      if (i > 0 && with_gaps && burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      send_word(pick_word());
      burst_left--;
    end
  endtask

  // let every expected sample come out, then wait on with the input idle
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // output side: compare each taken sample, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected filtered_sample, expected none, got %0d",
                 $time, $signed(m_tdata));
        error_count++;
      end else begin
        if (m_tdata !== pending_samples[0]) begin
          $display("%0t: filtered_sample mismatch, expected %0d, got %0d",
                   $time, $signed(pending_samples[0]), $signed(m_tdata));
          error_count++;
        end
        void'(pending_samples.pop_front());
      end
    end
    if (hold_pending && hold_left == 0) begin
      hold_left = hold_cycles;
      hold_pending = 1'b0;
    end
    pattern_phase = (pattern_phase + 1) % 7;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS:  m_tready <= 1'b1;
        READY_RANDOM:  m_tready <= ($urandom_range(0, 9) < 7);
        default:       m_tready <= (pattern_phase > 2);
      endcase
    end
  end

  // reset values, gate edge at the reset gain, truncation and extremes
  task automatic test_reset_defaults();
    ready_mode = READY_ALWAYS;
    send_word('0);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_3FFF);
    send_word(word_of(250));
    send_word(word_of(249));
    send_word(word_of(-250));
    send_word(word_of(-249));
    wait_for_results();
  endtask

  // gain extremes, truncation toward zero, upper bits of the gain write dropped
  task automatic test_gain_extremes();
    set_all(16'd4095, 16'd0, ALPHA_ONE);
    send_word(word_of(1));
    send_word(word_of(-1));
    send_word(32'h7FFF_FFFF);
    wait_for_results();
    set_register(REG_GAIN, 16'hF101);
    send_word(word_of(-300));
    set_register(REG_GAIN, 16'd0);
    send_word(32'h8000_0000);
    wait_for_results();
  endtask

  // gate off, threshold at full scale, threshold beyond full scale
  task automatic test_gate_edges();
    set_all(16'd4095, 16'd0, ALPHA_ONE);
    send_word(word_of(1));
    set_register(REG_GATE, 16'd32768);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    set_register(REG_GATE, 16'hFFFF);
    send_word(32'h8000_0000);
    wait_for_results();
  endtask

  // alpha zero holds the previous sample, alpha above one passes straight through
  task automatic test_alpha_limits();
    set_all(GAIN_RESET, 16'd0, 16'd0);
    send_word(32'h7FFF_FFFF);
    set_register(REG_ALPHA, 16'd32769);
    send_word(word_of(-12345));
    set_register(REG_ALPHA, 16'hFFFF);
    send_word(word_of(777));
    wait_for_results();
  endtask

  // a write to an index with no register leaves the settings alone
  task automatic test_unknown_index();
    set_all(16'd300, 16'd100, 16'd20000);
    set_register(REG_UNUSED, 16'hFFFF);
    send_word(word_of(5000));
    send_word(word_of(-5000));
    wait_for_results();
  endtask

  // fixed corner settings, then random settings per phase, random words, mixed idling on both sides
  task automatic test_random_traffic();
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] alpha;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin gain = 16'hFFFF; thr = 16'd0;     alpha = ALPHA_ONE; end
        1: begin gain = 16'd0;    thr = 16'hFFFF;  alpha = 16'd0;     end
        2: begin gain = 16'd1;    thr = 16'd32768; alpha = 16'd1;     end
        default: begin
          case ($urandom_range(0, 4))
            0: gain = 16'd0;
            1: gain = 16'hFFFF;
            2: gain = 16'd256;
            default: gain = CFG_W'($urandom);
          endcase
          case ($urandom_range(0, 4))
            0: thr = 16'd0;
            1: thr = 16'd32768;
            2: thr = CFG_W'($urandom);
            default: thr = CFG_W'($urandom_range(1, 3000));
          endcase
          case ($urandom_range(0, 4))
            0: alpha = 16'd0;
            1: alpha = ALPHA_ONE;
            2: alpha = CFG_W'($urandom_range(32769, 65535));
            default: alpha = CFG_W'($urandom_range(1, 32767));
          endcase
        end
      endcase
      set_all(gain, thr, alpha);
      ready_mode = ready_mode_t'(phase % 3);
      send_stream((phase < 3) ? 60 : 180, phase != 4);
      wait_for_results();
    end
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    set_all(GAIN_RESET, 16'd50, 16'd9000);
    ready_mode = READY_ALWAYS;
    hold_cycles = 150;
    hold_pending = 1'b1;
    send_stream(40, 1'b0);
    wait_for_results();
    ready_mode = READY_RANDOM;
    hold_cycles = 80;
    hold_pending = 1'b1;
    send_stream(30, 1'b1);
    wait_for_results();
  endtask

  initial begin
    model_gain = GAIN_RESET;
    model_threshold = GATE_RESET;
    model_alpha = ALPHA_RESET;
    model_prev = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_gain_extremes();
    test_gate_edges();
    test_alpha_limits();
    test_unknown_index();
    test_random_traffic();
    test_backpressure();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/mscc_pkg.sv
hdl/mic_sample_conditioning_chain.sv
bench/tb_mic_sample_conditioning_chain.sv
